// File: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console character writer
// Screen geometry, cell encoding, command record and sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // field widths fixed by the interface
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int INDEX_W = 11;
  localparam int OROW_W  = 5;
  localparam int OCOL_W  = 7;

  // internal widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  // cell constants
  localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h07;
  localparam logic [CHAR_W-1:0] SPACE_CODE  = 8'h20;
  localparam logic [CELL_W-1:0] BLANK_CELL  = {RESET_COLOR, SPACE_CODE};

  // scroll: cells moved up, and first cell of the bottom row
  localparam int COPY_LEN     = CELLS - COLUMNS;
  localparam int LAST_ROW_POS = (ROWS - 1) * COLUMNS;

  // command queue between front and back (depth a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input opcodes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_READ,
    CMD_READ_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_CLEAR
  } state_t;

endpackage

// File: hw/rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer: character-cell text console
// 80x25 screen of 16-bit cells (attribute high byte, character low byte)
// with put-character and read-cell commands and scroll on overflow.
// ----------------------------------------------------------------------------
// After reset the block clears the screen to spaces in color 7, one cell a
// clock, over all ROWS*COLUMNS cells; in_stall stays high during that pass,
// while the text color register can be written at any time. Each input
// transaction yields exactly one output transaction that carries the read
// cell (zero for a put or for an index past the screen) and the cursor
// after the transaction. Inputs pass an input register and a two-entry
// command queue, so up to three transactions are taken while a result
// waits to be taken. The back sequencer, built around the single-write,
// single-read screen memory, sets the pace: a put is one write, a read
// waits for the registered memory read, an out-of-range read makes no
// memory access, and a put that runs past the bottom row adds a scroll:
// one memory read and write per moved cell, then one write per cleared
// cell of the bottom row.
module text_console_char_writer (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcw_pkg::CELL_W-1:0]  cell_data,
  output logic [tcw_pkg::OROW_W-1:0]  cursor_row,
  output logic [tcw_pkg::OCOL_W-1:0]  cursor_col,
  // text color register
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wr_data
);
  import tcw_pkg::*;

  // front to queue
  logic              push;
  cmd_t              push_cmd;
  logic              q_full;
  // queue to back
  logic              q_valid;
  cmd_t              q_cmd;
  logic              pop;
  // back status: low while the reset clear is running
  logic              init_done;
  // screen memory ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  // result register, internal widths
  logic [ROW_W-1:0]  res_row;
  logic [COL_W-1:0]  res_col;

  // front: takes transactions, classifies put / read / read outside screen
  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (init_done),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .char_code  (char_code),
    .cell_index (cell_index),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  // decouples front and back so each can stall on its own
  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // back: cursor, screen writes, scroll and the result register
  tcw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .init_done   (init_done),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (cell_data),
    .out_row     (res_row),
    .out_col     (res_col)
  );

  // screen store, row-major
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // cursor fields at their port widths
  assign cursor_row = OROW_W'(res_row);
  assign cursor_col = OCOL_W'(res_col);

endmodule

// File: hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port ram
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: input stage
// Accepts input transactions, classifies them into commands and hands
// them to the command queue.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       enable,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       opcode,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
  output logic                       push,
  output tcw_pkg::cmd_t              push_cmd,
  input  logic                       q_full
);
  import tcw_pkg::*;

  logic f_valid;
  logic f_valid_next;
  cmd_t f_cmd;
  cmd_t cmd_next;
  logic accept;

  assign push     = f_valid && !q_full;
  assign push_cmd = f_cmd;
  assign in_stall = !enable || (f_valid && q_full);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd_next.char_code = char_code;
    cmd_next.addr      = ADDR_W'(cell_index);
    if (opcode == OP_PUT) begin
      cmd_next.kind = CMD_PUT;
    end else if (32'(cell_index) < 32'(CELLS)) begin
      cmd_next.kind = CMD_READ;
    end else begin
      // read outside the screen answers zero without a memory access
      cmd_next.kind = CMD_READ_NONE;
    end
  end

  always_comb begin
    priority if (accept) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end else begin
      f_valid_next = f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd <= cmd_next;
    end
  end

endmodule

// File: hw/rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue: command queue
// Short fifo of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output tcw_pkg::cmd_t q_cmd
);
  import tcw_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: execution sequencer
// Clears the screen after reset, executes put and read commands, runs the
// scroll copy and bottom-row clear, and holds the result register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  tcw_pkg::cmd_t              q_cmd,
  output logic                       pop,
  input  logic                       cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wr_data,
  output logic                       init_done,
  output logic                       ram_we,
  output logic [tcw_pkg::ADDR_W-1:0] ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
  output logic                       ram_re,
  output logic [tcw_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tcw_pkg::CELL_W-1:0] out_data,
  output logic [tcw_pkg::ROW_W-1:0]  out_row,
  output logic [tcw_pkg::COL_W-1:0]  out_col
);
  import tcw_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] pos_next;
  logic [ATTR_W-1:0] color;
  logic              out_valid_next;
  logic              out_free;
  logic              load;
  logic [CELL_W-1:0] load_data;

  assign out_free  = !out_valid || !out_stall;
  assign init_done = (state != ST_INIT);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    row_next   = row;
    col_next   = col;
    pos_next   = pos;
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    load       = 1'b0;
    load_data  = '0;

    unique case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[ADDR_W-1:0];
        ram_wdata = BLANK_CELL;
        if (cnt == CNT_W'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = pos;
              ram_wdata = {color, q_cmd.char_code};
              if (col == COL_W'(COLUMNS - 1)) begin
                col_next = '0;
                if (row == ROW_W'(ROWS - 1)) begin
                  pos_next   = ADDR_W'(LAST_ROW_POS);
                  cnt_next   = '0;
                  state_next = ST_COPY;
                end else begin
                  row_next = row + 1'b1;
                  pos_next = pos + 1'b1;
                  load     = 1'b1;
                end
              end else begin
                col_next = col + 1'b1;
                pos_next = pos + 1'b1;
                load     = 1'b1;
              end
            end
            CMD_READ: begin
              ram_re     = 1'b1;
              ram_raddr  = q_cmd.addr;
              state_next = ST_READ;
            end
            CMD_READ_NONE: begin
              load = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        load       = 1'b1;
        load_data  = ram_rdata;
        state_next = ST_IDLE;
      end

      ST_COPY: begin
        if (cnt < CNT_W'(COPY_LEN)) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(cnt + CNT_W'(COLUMNS));
        end
        if (cnt != '0) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(cnt - 1'b1);
          ram_wdata = ram_rdata;
        end
        if (cnt == CNT_W'(COPY_LEN)) begin
          state_next = ST_CLEAR;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[ADDR_W-1:0];
        ram_wdata = '0;
        if (cnt == CNT_W'(CELLS - 1)) begin
          cnt_next   = '0;
          load       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = out_valid && out_stall;
    if (load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      row       <= '0;
      col       <= '0;
      pos       <= '0;
      color     <= RESET_COLOR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      row       <= row_next;
      col       <= col_next;
      pos       <= pos_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        color <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
      out_row  <= row_next;
      out_col  <= col_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |-> !pop)
    else $error("command taken during screen clear");

  a_pos_tracks_cursor: assert property (@(posedge clk) disable iff (rst)
    32'(pos) == 32'(row) * COLUMNS + 32'(col))
    else $error("write position out of step with cursor");

  a_copy_no_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_raddr > ram_waddr))
    else $error("scroll read overlaps a pending write");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result register overwritten before it was taken");

  a_scroll_ends_bottom: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && state_next == ST_IDLE) |=>
      (row == ROW_W'(ROWS - 1) && col == '0 && out_valid))
    else $error("scroll did not leave cursor on bottom row");
`endif

endmodule

// File: bench/text_console_char_writer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_checker: result checker for the text console
// Watches the command, result and color ports, keeps its own screen, cursor
// and color, and compares every result with the oldest expected one.
// ----------------------------------------------------------------------------
module text_console_char_writer_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [tcw_pkg::CELL_W-1:0]  cell_data,
  input  logic [tcw_pkg::OROW_W-1:0]  cursor_row,
  input  logic [tcw_pkg::OCOL_W-1:0]  cursor_col,
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wr_data,
  output int                          mismatch_count,
  output int                          pending_results
);
  import tcw_pkg::*;

  typedef struct {
    logic [CELL_W-1:0] cell_value;
    logic [OROW_W-1:0] row;
    logic [OCOL_W-1:0] col;
  } console_result_t;

  logic [CELL_W-1:0] screen_model [CELLS];
  logic [ATTR_W-1:0] text_color;
  int                cur_row;
  int                cur_col;
  console_result_t   expected_results [$];
  console_result_t   next_result;
  console_result_t   oldest;

  task automatic report_mismatch(input string what, input logic [CELL_W-1:0] got,
                                 input logic [CELL_W-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic clear_console();
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    text_color = RESET_COLOR;
    cur_row = 0;
    cur_col = 0;
  endtask

  // rows move up by one, bottom row goes to zero
  task automatic scroll_screen();
    for (int i = 0; i < COPY_LEN; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = LAST_ROW_POS; i < CELLS; i++) screen_model[i] = '0;
  endtask

  task automatic predict_console(input logic op, input logic [CHAR_W-1:0] ch,
                                 input logic [INDEX_W-1:0] idx,
                                 output console_result_t res);
    res.cell_value = '0;
    if (op == OP_READ) begin
      if (idx < CELLS) res.cell_value = screen_model[idx];
    end else begin
      screen_model[cur_row * COLUMNS + cur_col] = {text_color, ch};
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
          scroll_screen();
          cur_row = ROWS - 1;
        end
      end
    end
    res.row = OROW_W'(cur_row);
    res.col = OCOL_W'(cur_col);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_console();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, cell_data", cell_data, '0);
        end else begin
          oldest = expected_results.pop_front();
          if (cell_data !== oldest.cell_value)
            report_mismatch("cell_data", cell_data, oldest.cell_value);
          if (cursor_row !== oldest.row)
            report_mismatch("cursor_row", CELL_W'(cursor_row), CELL_W'(oldest.row));
          if (cursor_col !== oldest.col)
            report_mismatch("cursor_col", CELL_W'(cursor_col), CELL_W'(oldest.col));
        end
      end
      if (in_valid && !in_stall) begin
        predict_console(opcode, char_code, cell_index, next_result);
        expected_results.push_back(next_result);
      end
      if (cfg_wr_en) text_color = cfg_wr_data;
    end
    pending_results = expected_results.size();
  end

endmodule

// File: bench/text_console_char_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_tb: testbench top for the text console
// Drives put and read commands with random gaps and result stalls, writes the
// text color between phases, fills the screen to force scrolls, and reports
// the verdict from the checker's mismatch and pending-result counts.
// ----------------------------------------------------------------------------
module text_console_char_writer_tb;
  import tcw_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 4;
  // slowest quiet stretch is the reset clear or a scroll, plus the longest
  // result stall and command gap
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 50;
  localparam int INDEX_MAX      = (1 << INDEX_W) - 1;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 100;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                opcode;
  logic [CHAR_W-1:0]   char_code;
  logic [INDEX_W-1:0]  cell_index;
  logic                out_valid;
  logic                out_stall;
  logic [CELL_W-1:0]   cell_data;
  logic [OROW_W-1:0]   cursor_row;
  logic [OCOL_W-1:0]   cursor_col;
  logic                cfg_wr_en;
  logic [ATTR_W-1:0]   cfg_wr_data;

  int                  mismatch_count;
  int                  pending_results;

  // idling controls, changed per phase
  logic                src_gaps_on;
  logic                sink_stall_on;
  int                  sink_hold;
  int                  quiet_cycles;
  int                  puts_sent;

  always #CLK_HALF clk = ~clk;

  text_console_char_writer u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .char_code   (char_code),
    .cell_index  (cell_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_data   (cell_data),
    .cursor_row  (cursor_row),
    .cursor_col  (cursor_col),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  text_console_char_writer_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cell_data       (cell_data),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // idle length from three ranges: mostly the shortest, rarely the longest
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  // reads lean toward the bottom rows, where scrolls leave their mark,
  // and past the end of the screen
  function automatic logic [INDEX_W-1:0] pick_read_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return INDEX_W'($urandom_range(CELLS, INDEX_MAX));
    if (r < 30) return INDEX_W'($urandom_range(LAST_ROW_POS, CELLS - 1));
    if (r < 40) return INDEX_W'($urandom_range(LAST_ROW_POS - COLUMNS, LAST_ROW_POS - 1));
    return INDEX_W'($urandom_range(0, CELLS - 1));
  endfunction

  // result-side back pressure: alternating free and stalled stretches
  always @(negedge clk) begin
    if (rst || !sink_stall_on) begin
      out_stall <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      sink_hold <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      sink_hold <= pick_len() - 1;
    end
  end

  // watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // entered and left at a falling edge; valid stays high across back-to-back
  // transactions so it is only assigned once per edge
  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    gap = (src_gaps_on && $urandom_range(0, 1)) ? pick_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    cell_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // the unused index field of a put is random garbage
  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(OP_PUT, ch, INDEX_W'($urandom_range(0, INDEX_MAX)));
    puts_sent++;
  endtask

  task automatic read_cell(input logic [INDEX_W-1:0] idx);
    send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  // wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // color changes only while the console is idle
  task automatic set_color(input logic [ATTR_W-1:0] color);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_PUT;
    char_code     = '0;
    cell_index    = '0;
    out_stall     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    src_gaps_on   = 1'b1;
    sink_stall_on = 1'b1;
    puts_sent     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset contents, range edges, character and color extremes
    set_color(8'hFF);
    read_cell(INDEX_W'(0));
    read_cell(INDEX_W'(CELLS - 1));
    read_cell(INDEX_W'(CELLS));          // first index past the screen
    read_cell(INDEX_W'(INDEX_MAX));      // every index bit set
    put_char(8'h00);
    put_char(8'hFF);
    read_cell(INDEX_W'(0));
    read_cell(INDEX_W'(1));
    set_color(8'h00);
    put_char(8'hAA);
    put_char(8'h55);
    read_cell(INDEX_W'(2));
    read_cell(INDEX_W'(3));
    read_cell(INDEX_W'(4));              // still blank

    // fill the screen up to its last cell, wrapping through every row
    set_color(8'h5A);
    sink_stall_on <= 1'b0;
    while (puts_sent < CELLS - 1) put_char(CHAR_W'($urandom_range(0, 255)));
    sink_stall_on <= 1'b1;
    read_cell(INDEX_W'(LAST_ROW_POS));
    read_cell(INDEX_W'(CELLS - 1));

    // last cell of the screen: this put scrolls
    set_color(8'hC3);
    put_char(8'h41);
    read_cell(INDEX_W'(LAST_ROW_POS - 1));   // old bottom row moved up
    read_cell(INDEX_W'(LAST_ROW_POS));       // cleared bottom row
    read_cell(INDEX_W'(CELLS - 1));
    read_cell(INDEX_W'(0));
    put_char(8'h42);
    read_cell(INDEX_W'(LAST_ROW_POS));

    // random phases: each gets its own color and idling mix, with two phases
    // free of source gaps and two free of result stalls, one of them free of both
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       set_color(8'h00);
        1:       set_color(8'hFF);
        default: set_color(ATTR_W'($urandom_range(0, 255)));
      endcase
      src_gaps_on   = (phase != 2) && (phase != 4);
      sink_stall_on <= (phase != 3) && (phase != 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 70)
          put_char(CHAR_W'($urandom_range(0, 255)));
        else
          read_cell(pick_read_index());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_char_writer.sv
bench/text_console_char_writer_checker.sv
bench/text_console_char_writer_tb.sv
